// ===== hdl/mono_framebuffer_draw_engine_assert.svh =====
// assertion macros for the draw engine, clocked on clk_i; only MFDE_ASSERT is disabled while rst_ni is low
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define MFDE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mfde: assertion failed");
`define MFDE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("mfde: assertion failed");
`else
`define MFDE_ASSERT(label, prop)
`define MFDE_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== hdl/mfde_pkg.sv =====
package mfde_pkg;

  // panel geometry
  localparam int unsigned ROW_COUNT     = 168;
  localparam int unsigned COLUMN_COUNT  = 144;
  localparam int unsigned BYTES_PER_ROW = (COLUMN_COUNT + 7) / 8;
  localparam int unsigned STORE_BYTES   = ROW_COUNT * BYTES_PER_ROW;
  localparam int unsigned ADDR_W        = $clog2(STORE_BYTES);
  // byte index of an 8-bit column, plus one for a write that spills over
  localparam int unsigned BYTE_W        = 6;

  localparam logic [2:0] LAST_BIT  = 3'h7;
  localparam logic [7:0] FULL_BYTE = 8'hff;

  typedef enum logic [1:0] {
    ACT_FILL  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] x_start;
    logic [7:0] x_end;
    logic [7:0] y_start;
    logic [7:0] y_end;
    logic       color;
    logic [7:0] src_bits;
    logic [2:0] src_offset;
    logic [3:0] bit_count;
    logic       palette_zero;
    logic       palette_one;
  } draw_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       refresh_valid;
    logic [7:0] refresh_first;
    logic [7:0] refresh_last;
  } draw_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic clear_write;
    logic mem_read;
    logic rmw_write;
  } dp_ctrl_t;

  typedef struct packed {
    logic clear_last;
    logic has_work;
    logic last_byte;
  } dp_status_t;

endpackage

// ===== hdl/mfde_ram.sv =====
module mfde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mfde_ctrl.sv =====
`include "mono_framebuffer_draw_engine_assert.svh"

module mfde_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mfde_pkg::dp_status_t status_i,
  output mfde_pkg::dp_ctrl_t   ctrl_o,
  output logic                busy_o,
  output logic                done_o
);

  mfde_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfde_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mfde_pkg::ST_CLEAR: begin
        if (status_i.clear_last) state_d = mfde_pkg::ST_IDLE;
      end
      mfde_pkg::ST_IDLE: begin
        if (start_i) state_d = status_i.has_work ? mfde_pkg::ST_READ : mfde_pkg::ST_DONE;
      end
      mfde_pkg::ST_READ:  state_d = mfde_pkg::ST_WRITE;
      mfde_pkg::ST_WRITE: begin
        state_d = status_i.last_byte ? mfde_pkg::ST_DONE : mfde_pkg::ST_READ;
      end
      mfde_pkg::ST_DONE:  state_d = mfde_pkg::ST_IDLE;
      default:            state_d = mfde_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      mfde_pkg::ST_CLEAR: ctrl_o.clear_write = 1'b1;
      mfde_pkg::ST_IDLE: begin
        busy_o      = 1'b0;
        ctrl_o.load = start_i;
      end
      mfde_pkg::ST_READ:  ctrl_o.mem_read  = 1'b1;
      mfde_pkg::ST_WRITE: ctrl_o.rmw_write = 1'b1;
      mfde_pkg::ST_DONE:  done_o = 1'b1;
      default: ;
    endcase
  end

  // every modify-write uses the byte fetched in the cycle before
  `MFDE_ASSERT(a_write_after_read, ctrl_o.rmw_write |-> $past(ctrl_o.mem_read))
  `MFDE_ASSERT(a_load_sets_busy, ctrl_o.load |=> busy_o)
  `MFDE_ASSERT_ALWAYS(a_done_while_busy, !(done_o && !busy_o))

endmodule

// ===== hdl/mfde_datapath.sv =====
`include "mono_framebuffer_draw_engine_assert.svh"

module mfde_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mfde_pkg::draw_cmd_t  cmd_i,
  input  mfde_pkg::dp_ctrl_t   ctrl_i,
  output mfde_pkg::dp_status_t status_o,
  output mfde_pkg::draw_res_t  result_o
);

  localparam int unsigned AW = mfde_pkg::ADDR_W;
  localparam int unsigned BW = mfde_pkg::BYTE_W;

  // decode of the incoming command
  logic [7:0]           x_end_c, y_end_c;
  logic [3:0]           room_c, cnt_c;
  logic [7:0]           src_sh_c;
  logic [15:0]          wmask_c, wdata_c;
  logic                 has_work_c;
  logic [BW-1:0]        b_first_c, b_last_c;
  logic [7:0]           row_last_c;
  mfde_pkg::draw_res_t  res_c;

  // item registers
  mfde_pkg::action_e    act_q;
  logic                 color_q;
  logic [2:0]           lo_q, hi_q;
  logic [BW-1:0]        b_first_q, b_last_q, byte_q;
  logic [7:0]           row_q, row_last_q;
  logic [15:0]          wmask_q, wdata_q;
  mfde_pkg::draw_res_t  res_q;
  logic [AW-1:0]        clr_cnt_q;

  // byte update
  logic [2:0]           lo_eff, hi_eff;
  logic [7:0]           fill_mask, byte_mask, byte_data, merged;
  logic                 first_sel;
  logic [AW-1:0]        rmw_addr, ram_addr;
  logic                 ram_we;
  logic [7:0]           ram_wdata, ram_rdata;

  always_comb begin
    x_end_c = (int'(cmd_i.x_end) > mfde_pkg::COLUMN_COUNT - 1)
              ? 8'(mfde_pkg::COLUMN_COUNT - 1) : cmd_i.x_end;
    y_end_c = (int'(cmd_i.y_end) > mfde_pkg::ROW_COUNT - 1)
              ? 8'(mfde_pkg::ROW_COUNT - 1) : cmd_i.y_end;
    room_c   = 4'd8 - {1'b0, cmd_i.src_offset};
    cnt_c    = (cmd_i.bit_count > room_c) ? room_c : cmd_i.bit_count;
    src_sh_c = cmd_i.src_bits << cmd_i.src_offset;
    wmask_c  = '0;
    wdata_c  = '0;
    // source pixels laid into a two-byte window starting at the first bit
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) < cnt_c) && (int'(cmd_i.x_start) + i < mfde_pkg::COLUMN_COUNT)) begin
        wmask_c[4'({1'b0, cmd_i.x_start[2:0]}) + 4'(i)] = 1'b1;
        wdata_c[4'({1'b0, cmd_i.x_start[2:0]}) + 4'(i)] =
          src_sh_c[7-i] ? cmd_i.palette_one : cmd_i.palette_zero;
      end
    end
  end

  always_comb begin
    has_work_c = 1'b0;
    b_first_c  = BW'(cmd_i.x_start[7:3]);
    b_last_c   = BW'(cmd_i.x_start[7:3]);
    row_last_c = cmd_i.y_start;
    res_c      = '0;
    case (cmd_i.action)
      mfde_pkg::ACT_FILL: begin
        has_work_c = (cmd_i.x_start <= x_end_c) && (cmd_i.y_start <= y_end_c);
        b_last_c   = BW'(x_end_c[7:3]);
        row_last_c = y_end_c;
        if (has_work_c) begin
          res_c.refresh_valid = 1'b1;
          res_c.refresh_first = cmd_i.y_start;
          res_c.refresh_last  = y_end_c;
        end
      end
      mfde_pkg::ACT_WRITE: begin
        has_work_c = (int'(cmd_i.y_start) < mfde_pkg::ROW_COUNT) && (wmask_c != '0);
        b_last_c   = BW'(cmd_i.x_start[7:3]) + BW'(wmask_c[15:8] != '0);
        if (has_work_c) begin
          res_c.refresh_valid = 1'b1;
          res_c.refresh_first = cmd_i.y_start;
          res_c.refresh_last  = cmd_i.y_start;
        end
      end
      mfde_pkg::ACT_READ: begin
        has_work_c = (int'(cmd_i.y_start) < mfde_pkg::ROW_COUNT)
                     && (int'(cmd_i.x_start) < mfde_pkg::COLUMN_COUNT);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctrl_i.clear_write) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      act_q      <= cmd_i.action;
      color_q    <= cmd_i.color;
      lo_q       <= cmd_i.x_start[2:0];
      hi_q       <= x_end_c[2:0];
      b_first_q  <= b_first_c;
      b_last_q   <= b_last_c;
      byte_q     <= b_first_c;
      row_q      <= cmd_i.y_start;
      row_last_q <= row_last_c;
      wmask_q    <= wmask_c;
      wdata_q    <= wdata_c;
      res_q      <= res_c;
    end else if (ctrl_i.rmw_write) begin
      if (byte_q == b_last_q) begin
        byte_q <= b_first_q;
        row_q  <= row_q + 8'd1;
      end else begin
        byte_q <= byte_q + BW'(1);
      end
      if (act_q == mfde_pkg::ACT_READ) res_q.read_data <= ram_rdata;
    end
  end

  always_comb begin
    lo_eff    = (byte_q == b_first_q) ? lo_q : 3'd0;
    hi_eff    = (byte_q == b_last_q) ? hi_q : mfde_pkg::LAST_BIT;
    fill_mask = (mfde_pkg::FULL_BYTE << lo_eff)
                & (mfde_pkg::FULL_BYTE >> (mfde_pkg::LAST_BIT - hi_eff));
    first_sel = (byte_q == b_first_q);
    if (act_q == mfde_pkg::ACT_FILL) begin
      byte_mask = fill_mask;
      byte_data = {8{color_q}};
    end else begin
      byte_mask = first_sel ? wmask_q[7:0] : wmask_q[15:8];
      byte_data = first_sel ? wdata_q[7:0] : wdata_q[15:8];
    end
    merged = (ram_rdata & ~byte_mask) | (byte_data & byte_mask);
  end

  assign rmw_addr  = AW'(row_q) * AW'(mfde_pkg::BYTES_PER_ROW) + AW'(byte_q);
  assign ram_addr  = ctrl_i.clear_write ? clr_cnt_q : rmw_addr;
  assign ram_we    = ctrl_i.clear_write
                     || (ctrl_i.rmw_write && (act_q != mfde_pkg::ACT_READ));
  assign ram_wdata = ctrl_i.clear_write ? 8'h00 : merged;

  mfde_ram #(
    .WIDTH (8),
    .DEPTH (mfde_pkg::STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ctrl_i.mem_read),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign status_o.clear_last = (clr_cnt_q == AW'(mfde_pkg::STORE_BYTES - 1));
  assign status_o.has_work   = has_work_c;
  assign status_o.last_byte  = (byte_q == b_last_q) && (row_q == row_last_q);
  assign result_o            = res_q;

  // clipping must keep every access inside the store
  `MFDE_ASSERT(a_addr_in_store, ctrl_i.mem_read |-> (int'(rmw_addr) < mfde_pkg::STORE_BYTES))
  `MFDE_ASSERT(a_refresh_order, ctrl_i.load |=> (res_q.refresh_first <= res_q.refresh_last))

endmodule

// ===== hdl/mono_framebuffer_draw_engine.sv =====
// sequence: each stored byte that a fill, write or read touches gets a read state, then a
//   write state (a read item writes nothing back); the result strobe follows in the cycle after
//   the last byte; an item with nothing to do strobes its result in the cycle after acceptance
// a new item is taken only in idle, after the last one's done strobe; the frame store is single-port
// reset: the store is swept to zero, one byte a cycle, across all 3024 bytes with busy held high
// the receiver cannot stall: each result is shown for exactly one cycle on done_o
module mono_framebuffer_draw_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mfde_pkg::draw_cmd_t cmd_i,
  output logic                done_o,
  output mfde_pkg::draw_res_t result_o
);

  // command and status between sequencer and datapath
  mfde_pkg::dp_ctrl_t   dp_ctrl;
  mfde_pkg::dp_status_t dp_status;

  // sequencer: clearing sweep, then read/modify/write per byte of each transaction
  mfde_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (dp_status),
    .ctrl_o   (dp_ctrl),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // datapath: clipping, masks, byte walk and the frame store itself
  mfde_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .ctrl_i   (dp_ctrl),
    .status_o (dp_status),
    .result_o (result_o)
  );

endmodule
